### hdl/fibadd_pkg.sv
// Shared definitions for the fibinary adder: field widths, parameter defaults
// and the command bundle from the controller to the datapath.
// No dependencies.
package fibadd_pkg;

  localparam int OPERAND_DIGITS_DEF = 32;
  localparam int ADDEND_W = 32;

  typedef struct packed {
    logic load;
    logic accum;
    logic convert;
    logic publish;
  } fibadd_cmd_t;

endpackage

### hdl/fibadd_dp.sv
// Datapath of the fibinary adder: operand shift registers, Fibonacci weight
// pair, binary accumulator, greedy digit extraction and the output register.
// Depends on fibadd_pkg.
module fibadd_dp
  import fibadd_pkg::*;
#(
  parameter int OPERAND_DIGITS = OPERAND_DIGITS_DEF,
  parameter int OUT_W = 40
) (
  input  logic                clk,
  input  logic [ADDEND_W-1:0] addend_a,
  input  logic [ADDEND_W-1:0] addend_b,
  input  fibadd_cmd_t         cmd,
  output logic [OUT_W-1:0]    sum_out
);

  localparam int SUM_W = OPERAND_DIGITS + 3;
  localparam int VAL_W = SUM_W + 1;

  logic [ADDEND_W-1:0] a;
  logic [ADDEND_W-1:0] b;
  logic [ADDEND_W-1:0] digit_mask;
  logic [VAL_W-1:0]    v;
  logic [VAL_W-1:0]    wlo;
  logic [VAL_W-1:0]    whi;
  logic [VAL_W-1:0]    addend;
  logic [SUM_W-1:0]    r;
  logic                take;

  always_comb begin
    for (int i = 0; i < ADDEND_W; i++) begin
      digit_mask[i] = (i < OPERAND_DIGITS);
    end
  end

  always_comb begin
    unique case ({a[0], b[0]})
      2'b11:   addend = {wlo[VAL_W-2:0], 1'b0};
      2'b01,
      2'b10:   addend = wlo;
      default: addend = '0;
    endcase
  end

  assign take = (wlo <= v);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a   <= addend_a & digit_mask;
      b   <= addend_b & digit_mask;
      v   <= '0;
      wlo <= VAL_W'(1);
      whi <= VAL_W'(2);
    end else if (cmd.accum) begin
      a   <= a >> 1;
      b   <= b >> 1;
      v   <= v + addend;
      wlo <= whi;
      whi <= whi + wlo;
    end else if (cmd.convert) begin
      if (take) begin
        v <= v - wlo;
      end
      r   <= {r[SUM_W-2:0], take};
      wlo <= whi - wlo;
      whi <= wlo;
    end
    if (cmd.publish) begin
      sum_out <= OUT_W'(r);
    end
  end

endmodule

### hdl/fibadd_ctrl.sv
// Controller of the fibinary adder: sequences load, accumulate, convert and
// hand-off to the output register, and owns the input and output handshakes.
// Depends on fibadd_pkg.
module fibadd_ctrl
  import fibadd_pkg::*;
#(
  parameter int OPERAND_DIGITS = OPERAND_DIGITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output fibadd_cmd_t cmd
);

  localparam int CNT_W = $clog2(OPERAND_DIGITS + 3);

  typedef enum logic [1:0] {
    IDLE,
    ACCUM,
    CONVERT,
    HOLD
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  cnt;
  logic              slot_free;

  assign slot_free   = !out_valid || out_ready;
  assign in_ready    = (state == IDLE);
  assign cmd.load    = (state == IDLE) && in_valid;
  assign cmd.accum   = (state == ACCUM);
  assign cmd.convert = (state == CONVERT);
  assign cmd.publish = (state == HOLD) && slot_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (in_valid) begin
            state <= ACCUM;
            cnt   <= CNT_W'(OPERAND_DIGITS + 1);
          end
        end
        ACCUM: begin
          if (cnt == '0) begin
            state <= CONVERT;
            cnt   <= CNT_W'(OPERAND_DIGITS + 2);
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        CONVERT: begin
          if (cnt == '0) begin
            state <= HOLD;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        HOLD: begin
          if (slot_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### hdl/fibinary_adder.sv
// Top level of the fibinary adder: stream ports, controller and datapath.
// Depends on fibadd_pkg, fibadd_ctrl and fibadd_dp.
//
// Adds two Zeckendorf numbers (digit k weighs F(k+2)) and returns the
// canonical sum, which never has two adjacent ones. Each beat is processed
// one at a time: after a load step, the ACCUM state walks the operand
// digits and accumulates the binary value with a running Fibonacci weight
// pair, then the CONVERT state extracts the sum digits from the top down
// with one compare and subtract per cycle, and a HOLD state hands the sum
// off to the output register.
// The result sits in an output register, so the next beat is accepted while
// it waits. Operand digits at or above OPERAND_DIGITS are ignored.
module fibinary_adder
  import fibadd_pkg::*;
#(
  parameter int OPERAND_DIGITS = OPERAND_DIGITS_DEF
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         s_tvalid,
  output logic                                         s_tready,
  // Fields from bit 0: addend_a[31:0], addend_b[31:0].
  input  logic [2*ADDEND_W-1:0]                        s_tdata,
  output logic                                         m_tvalid,
  input  logic                                         m_tready,
  // Fields from bit 0: sum_digits[OPERAND_DIGITS+2:0], then zero padding.
  output logic [((OPERAND_DIGITS + 3 + 7) / 8) * 8-1:0] m_tdata
);

  localparam int SUM_W = OPERAND_DIGITS + 3;
  localparam int OUT_W = ((OPERAND_DIGITS + 3 + 7) / 8) * 8;

  fibadd_cmd_t cmd;

  fibadd_ctrl #(
    .OPERAND_DIGITS(OPERAND_DIGITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .cmd      (cmd)
  );

  fibadd_dp #(
    .OPERAND_DIGITS(OPERAND_DIGITS),
    .OUT_W         (OUT_W)
  ) u_dp (
    .clk     (clk),
    .addend_a(s_tdata[ADDEND_W-1:0]),
    .addend_b(s_tdata[2*ADDEND_W-1:ADDEND_W]),
    .cmd     (cmd),
    .sum_out (m_tdata)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("second beat accepted while one is in progress");

  a_canonical: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((m_tdata[SUM_W-1:0] & (m_tdata[SUM_W-1:0] >> 1)) == '0))
    else $error("sum has two adjacent ones");

  a_publish_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.publish |=> m_tvalid)
    else $error("published result not presented");

endmodule

### dv/fibinary_adder_tb.sv
// Self-checking testbench for fibinary_adder: directed and random operand pairs
// go in on the slave stream, and every sum beat is compared with a predicted value.
// Depends on fibadd_pkg and the fibinary_adder RTL.
module fibinary_adder_tb;
  import fibadd_pkg::*;

  localparam int DIGITS = OPERAND_DIGITS_DEF;
  localparam int SUM_W = DIGITS + 3;
  localparam int OUT_W = ((DIGITS + 3 + 7) / 8) * 8;
  localparam int STALL_LIMIT = 4000;

  typedef struct {
    logic [ADDEND_W-1:0] a;
    logic [ADDEND_W-1:0] b;
    logic [OUT_W-1:0]    sum;
  } sum_entry_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [2*ADDEND_W-1:0] s_tdata;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_W-1:0]      m_tdata;

  sum_entry_t pending_sums[$];
  int         mismatch_count;
  int         quiet_cycles;
  int         send_idle_pct;
  int         recv_stall_pct;

  fibinary_adder #(
    .OPERAND_DIGITS(DIGITS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [SUM_W-1:0] zeckendorf_sum(input logic [ADDEND_W-1:0] a,
                                                      input logic [ADDEND_W-1:0] b);
    longint unsigned weight[SUM_W];
    longint unsigned total;
    logic [SUM_W-1:0] digits;
    weight[0] = 1;
    weight[1] = 2;
    for (int k = 2; k < SUM_W; k++) weight[k] = weight[k-1] + weight[k-2];
    total = 0;
    for (int k = 0; k < DIGITS && k < ADDEND_W; k++) begin
      if (a[k]) total += weight[k];
      if (b[k]) total += weight[k];
    end
    digits = '0;
    for (int k = SUM_W - 1; k >= 0; k--) begin
      if (weight[k] <= total) begin
        digits[k] = 1'b1;
        total -= weight[k];
      end
    end
    return digits;
  endfunction

  function automatic logic [ADDEND_W-1:0] random_canonical(input int density_pct);
    logic [ADDEND_W-1:0] digits;
    digits = '0;
    for (int k = 0; k < ADDEND_W; k++) begin
      if ((k == 0 || !digits[k-1]) && $urandom_range(99) < density_pct) digits[k] = 1'b1;
    end
    return digits;
  endfunction

  function automatic logic [ADDEND_W-1:0] random_raw();
    case ($urandom_range(3))
      0: return $urandom & $urandom & $urandom;
      1: return $urandom | $urandom;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_addends(input logic [ADDEND_W-1:0] a, input logic [ADDEND_W-1:0] b);
    sum_entry_t entry;
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom};
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, a};
    do @(posedge clk); while (!s_tready);
    entry.a   = a;
    entry.b   = b;
    entry.sum = OUT_W'(zeckendorf_sum(a, b));
    pending_sums.push_back(entry);
    @(negedge clk);
  endtask

  task automatic test_extremes();
    send_addends('0, '0);
    send_addends('1, '1);
    send_addends('1, '0);
    send_addends('0, '1);
    send_addends(32'h8000_0000, 32'h8000_0000);
    send_addends(32'hFFFF_FFFF, 32'h0000_0001);
    send_addends(32'h0000_0001, 32'hFFFF_FFFF);
    send_addends(32'h5555_5555, 32'hAAAA_AAAA);
    send_addends(32'hAAAA_AAAA, 32'hAAAA_AAAA);
  endtask

  task automatic test_low_digits();
    send_addends(32'h0000_0001, 32'h0000_0001);
    send_addends(32'h0000_0002, 32'h0000_0002);
    send_addends(32'h0000_0001, 32'h0000_0002);
    send_addends(32'h0000_0003, 32'h0000_0000);
    send_addends(32'h0000_0003, 32'h0000_0003);
  endtask

  task automatic test_noncanonical();
    send_addends(32'h5555_5555, 32'h5555_5555);
    send_addends(32'h5555_5555, 32'h0000_0001);
    send_addends(32'h2AAA_AAAA, 32'h0000_0001);
    send_addends(32'h8000_0000, 32'h4000_0000);
    send_addends(32'hC000_0000, 32'hC000_0000);
    send_addends(32'h1234_5678, 32'h9ABC_DEF0);
  endtask

  task automatic test_random_canonical(input int count);
    for (int i = 0; i < count; i++) begin
      send_addends(random_canonical($urandom_range(10, 100)),
                   random_canonical($urandom_range(10, 100)));
    end
  endtask

  task automatic test_random_raw(input int count);
    for (int i = 0; i < count; i++) send_addends(random_raw(), random_raw());
  endtask

  always @(negedge clk) begin
    if (!rst) m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (m_tvalid && m_tready) begin
        if (pending_sums.size() == 0) begin
          $display("%0t: unexpected sum beat, expected none, actual %h", $time, m_tdata);
          mismatch_count++;
        end else begin
          if (m_tdata !== pending_sums[0].sum) begin
            $display("%0t: sum mismatch for a=%h b=%h: expected %h, actual %h", $time,
                     pending_sums[0].a, pending_sums[0].b, pending_sums[0].sum, m_tdata);
            mismatch_count++;
          end
          void'(pending_sums.pop_front());
        end
      end
    end
  end

  initial begin
    wait (rst === 1'b0);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("fibinary_adder test failed");
    $finish;
  end

  initial begin
    clk            = 1'b0;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    m_tready       = 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extremes();
    test_low_digits();
    test_noncanonical();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_canonical(120);
    test_random_raw(40);
    send_idle_pct  = 59;
    recv_stall_pct = 0;
    test_random_canonical(120);
    test_random_raw(40);
    send_idle_pct  = 0;
    recv_stall_pct = 59;
    test_random_canonical(120);
    test_random_raw(40);
    send_idle_pct  = 29;
    recv_stall_pct = 29;
    test_random_canonical(120);
    test_random_raw(40);

    s_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (2 * DIGITS + 20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("fibinary_adder test passed");
    end else begin
      $display("fibinary_adder test failed");
    end
    $finish;
  end
endmodule
